/* rtl/vwd_pkg.sv */
// ----------------------------------------------------------------------------
// Varint window decoder package
// Shared types and constants for the lanes, the merge and the top level.
// ----------------------------------------------------------------------------
package vwd_pkg;

	localparam int WinBytes = 10;
	localparam int ValW     = 64;
	localparam int LenW     = 4;
	localparam int IdxW     = 4;

	localparam logic [IdxW-1:0] WIN_LEN   = 4'd10;
	localparam logic [IdxW-1:0] LIM_SHORT = 4'd2;
	localparam logic [IdxW-1:0] LIM_WORD  = 4'd5;
	localparam logic [IdxW-1:0] LIM_LONG  = 4'd10;
	localparam logic [7:0]      CONT_BIT  = 8'h80;
	localparam logic [7:0]      PAY_MASK  = 8'h7F;
	localparam logic [7:0]      ALL_ONES  = 8'hFF;

	typedef enum logic [2:0] {
		OP_UINT8  = 3'd0,
		OP_UINT32 = 3'd1,
		OP_UINT64 = 3'd2,
		OP_INT32  = 3'd3,
		OP_INT64  = 3'd4,
		OP_SINT32 = 3'd5,
		OP_SINT64 = 3'd6
	} op_t;

	typedef struct packed {
		logic            incl;
		logic            cont;
		logic            ones;
		logic [ValW-1:0] part;
	} lane_out_t;

	typedef struct packed {
		logic [ValW-1:0] acc;
		logic [LenW-1:0] len;
		logic [2:0]      op;
	} merged_t;

endpackage

/* rtl/vwd_lane.sv */
// ----------------------------------------------------------------------------
// Varint window decoder lane
// Decides whether one window byte belongs to the varint and places its bits.
// ----------------------------------------------------------------------------
module vwd_lane
	import vwd_pkg::*;
#(
	parameter int LANE = 0
) (
	input  logic [7:0]      byte_in,
	input  logic [IdxW-1:0] limit,
	input  logic [IdxW-1:0] avail,
	input  logic            chain_in,
	output logic            chain_out,
	output lane_out_t       res
);

	localparam logic [IdxW-1:0] IDX   = IdxW'(LANE);
	localparam logic [IdxW-1:0] IDX_1 = IdxW'(LANE + 1);
	localparam int              SH    = 7 * LANE;

	logic       full;
	logic       incl;
	logic [7:0] part8;

	always_comb begin
		full      = (limit == IDX_1);
		incl      = chain_in && (IDX < limit) && (IDX < avail);
		part8     = full ? byte_in : (byte_in & PAY_MASK);
		chain_out = chain_in && ((byte_in & CONT_BIT) != 8'd0);
		res.incl  = incl;
		res.cont  = (byte_in & CONT_BIT) != 8'd0;
		res.ones  = (byte_in == ALL_ONES);
		res.part  = incl ? (ValW'(part8) << SH) : '0;
	end

endmodule

/* rtl/vwd_merge.sv */
// ----------------------------------------------------------------------------
// Varint window decoder merge
// Combines the lane results into raw value bits and the consumed length.
// ----------------------------------------------------------------------------
module vwd_merge
	import vwd_pkg::*;
(
	input  lane_out_t lanes [WinBytes],
	input  op_t       op,
	output merged_t   res
);

	logic [ValW-1:0] acc;
	logic [LenW-1:0] n;
	logic            fail;
	logic            nxt;
	logic            special;

	always_comb begin
		acc  = '0;
		n    = '0;
		fail = 1'b0;
		for (int i = 0; i < WinBytes; i++) begin
			nxt  = (i == WinBytes - 1) ? 1'b0 : lanes[(i == WinBytes - 1) ? i : i + 1].incl;
			acc  = acc | lanes[i].part;
			if (lanes[i].incl) begin
				n = LenW'(i + 1);
			end
			fail = fail | (lanes[i].incl & ~nxt & lanes[i].cont);
		end
		special = (op == OP_INT32) && fail && lanes[4].cont && lanes[5].ones;
		res.acc = acc;
		res.op  = op;
		if (!lanes[0].incl) begin
			res.len = '0;
		end else if (special) begin
			res.len = WIN_LEN;
		end else if (fail) begin
			res.len = '0;
		end else begin
			res.len = n;
		end
	end

endmodule

/* rtl/varint_window_decoder.sv */
// ----------------------------------------------------------------------------
// Varint window decoder
// Decodes one base-128 varint, with zig-zag mapping, from a ten byte window.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                   tuser
//  s_*      in   byte_0..byte_9 [79:0], bytes_available  opcode [2:0]
//                [83:80], zero pad [87:84]
//  m_*      out  decoded_value [63:0], bytes_read [67:64] -
//                zero pad [71:68]
//
// The byte lanes and the merge fill the first register stage, the type width
// and zig-zag mapping fill the output register. One word is accepted in every
// cycle while the output is taken. A stalled output holds the output register,
// and the first stage too while it is full; reset empties them.
// ----------------------------------------------------------------------------
module varint_window_decoder
	import vwd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // byte_0 .. byte_9, bytes_available
	input  logic [2:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // decoded_value, bytes_read
);

	logic [IdxW-1:0] avail_raw;
	logic [IdxW-1:0] avail;
	logic [IdxW-1:0] limit;
	op_t             op_in;
	logic [WinBytes:0] chain;
	lane_out_t       lanes [WinBytes];
	merged_t         merged;

	merged_t         merged_s1;
	logic            valid_s1;
	logic [ValW-1:0] value_s2;
	logic [LenW-1:0] len_s2;
	logic            valid_s2;

	logic            adv_s1;
	logic            adv_s2;
	logic [ValW-1:0] fin_value;
	logic [31:0]     low32;

	assign avail_raw = s_tdata[8*WinBytes +: IdxW];
	assign avail     = (avail_raw > WIN_LEN) ? WIN_LEN : avail_raw;
	assign op_in     = op_t'(s_tuser);
	assign chain[0]  = 1'b1;

	always_comb begin
		case (op_in)
			OP_UINT8: begin
				limit = LIM_SHORT;
			end
			OP_UINT32, OP_INT32, OP_SINT32: begin
				limit = LIM_WORD;
			end
			OP_UINT64, OP_INT64, OP_SINT64: begin
				limit = LIM_LONG;
			end
			default: begin
				limit = '0;
			end
		endcase
	end

	for (genvar g = 0; g < WinBytes; g++) begin : g_lane
		vwd_lane #(
			.LANE(g)
		) u_lane (
			.byte_in  (s_tdata[8*g +: 8]),
			.limit    (limit),
			.avail    (avail),
			.chain_in (chain[g]),
			.chain_out(chain[g+1]),
			.res      (lanes[g])
		);
	end

	vwd_merge u_merge (
		.lanes(lanes),
		.op   (op_in),
		.res  (merged)
	);

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			merged_s1 <= merged;
		end
		if (adv_s2 && valid_s1) begin
			value_s2 <= fin_value;
			len_s2   <= merged_s1.len;
		end
	end

	always_comb begin
		low32 = merged_s1.acc[31:0];
		case (op_t'(merged_s1.op))
			OP_UINT8: begin
				fin_value = {56'd0, merged_s1.acc[7:0]};
			end
			OP_UINT32, OP_INT32: begin
				fin_value = {32'd0, low32};
			end
			OP_SINT32: begin
				fin_value = {32'd0, (low32 >> 1) ^ {32{low32[0]}}};
			end
			OP_SINT64: begin
				fin_value = (merged_s1.acc >> 1) ^ {ValW{merged_s1.acc[0]}};
			end
			default: begin
				fin_value = merged_s1.acc;
			end
		endcase
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, len_s2, value_s2};

endmodule

/* rtl/vwd_checker.sv */
// ----------------------------------------------------------------------------
// Varint window decoder checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module vwd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [87:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	a_ready_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

	a_ready_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[67:64] <= 4'd10) && (m_tdata[71:68] == 4'd0))
		else $error("length out of range or pad bits set");

endmodule

bind varint_window_decoder vwd_checker u_vwd_checker (.*);
